### design/ctok_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctok_pkg
// Token kinds, character codes, the token record and the byte classifiers
// shared by the tokenizer and its checker.
// ----------------------------------------------------------------------------
package ctok_pkg;

  localparam int BYTE_W     = 8;
  localparam int KIND_W     = 5;
  localparam int LINE_W     = 20;
  localparam int START_W    = 24;
  localparam int LEN_W      = 16;
  localparam int KW_LEN_MAX = 6;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_EOF      = 5'd0;
  localparam kind_t KIND_NUMBER   = 5'd1;
  localparam kind_t KIND_IDENT    = 5'd2;
  localparam kind_t KIND_INT      = 5'd3;
  localparam kind_t KIND_VOID     = 5'd4;
  localparam kind_t KIND_ASM      = 5'd5;
  localparam kind_t KIND_RETURN   = 5'd6;
  localparam kind_t KIND_IF       = 5'd7;
  localparam kind_t KIND_WHILE    = 5'd8;
  localparam kind_t KIND_PRINT    = 5'd9;
  localparam kind_t KIND_PLUS     = 5'd10;
  localparam kind_t KIND_MINUS    = 5'd11;
  localparam kind_t KIND_STAR     = 5'd12;
  localparam kind_t KIND_SLASH    = 5'd13;
  localparam kind_t KIND_EQEQ     = 5'd14;
  localparam kind_t KIND_ASSIGN   = 5'd15;
  localparam kind_t KIND_NE       = 5'd16;
  localparam kind_t KIND_LE       = 5'd17;
  localparam kind_t KIND_LT       = 5'd18;
  localparam kind_t KIND_GE       = 5'd19;
  localparam kind_t KIND_GT       = 5'd20;
  localparam kind_t KIND_LPAREN   = 5'd21;
  localparam kind_t KIND_RPAREN   = 5'd22;
  localparam kind_t KIND_LBRACE   = 5'd23;
  localparam kind_t KIND_RBRACE   = 5'd24;
  localparam kind_t KIND_LBRACKET = 5'd25;
  localparam kind_t KIND_RBRACKET = 5'd26;
  localparam kind_t KIND_SEMI     = 5'd27;
  localparam kind_t KIND_COMMA    = 5'd28;

  localparam logic [BYTE_W-1:0] CH_NL   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_US   = "_";
  localparam logic [BYTE_W-1:0] CH_EQ   = "=";
  localparam logic [BYTE_W-1:0] CH_BANG = "!";
  localparam logic [BYTE_W-1:0] CH_LT   = "<";
  localparam logic [BYTE_W-1:0] CH_GT   = ">";

  typedef struct packed {
    kind_t              kind;
    logic [LINE_W-1:0]  line;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   length;
    logic               final_tok;
    logic               run_last;
  } token_t;

  function automatic logic is_digit(input logic [BYTE_W-1:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  // Letters and underscore: the characters that may open an identifier.
  function automatic logic is_alpha_us(input logic [BYTE_W-1:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == CH_US);
  endfunction

  function automatic logic is_space(input logic [BYTE_W-1:0] b);
    return (b == " ") || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  // Single-character punctuation; anything else maps to the unknown kind.
  function automatic kind_t punct_kind(input logic [BYTE_W-1:0] b);
    kind_t k;
    k = KIND_EOF;
    case (b)
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      "/":     k = KIND_SLASH;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      "[":     k = KIND_LBRACKET;
      "]":     k = KIND_RBRACKET;
      ";":     k = KIND_SEMI;
      ",":     k = KIND_COMMA;
      default: k = KIND_EOF;
    endcase
    return k;
  endfunction

  // Element 0 of c holds the first character of the identifier.
  function automatic kind_t keyword_kind(input logic [KW_LEN_MAX-1:0][BYTE_W-1:0] c,
                                         input logic [LEN_W-1:0] cnt);
    kind_t k;
    k = KIND_IDENT;
    if ((cnt == 16'd3) && ({c[0], c[1], c[2]} == "int")) k = KIND_INT;
    if ((cnt == 16'd4) && ({c[0], c[1], c[2], c[3]} == "void")) k = KIND_VOID;
    if ((cnt == 16'd3) && ({c[0], c[1], c[2]} == "asm")) k = KIND_ASM;
    if ((cnt == 16'd6) && ({c[0], c[1], c[2], c[3], c[4], c[5]} == "return")) k = KIND_RETURN;
    if ((cnt == 16'd2) && ({c[0], c[1]} == "if")) k = KIND_IF;
    if ((cnt == 16'd5) && ({c[0], c[1], c[2], c[3], c[4]} == "while")) k = KIND_WHILE;
    if ((cnt == 16'd5) && ({c[0], c[1], c[2], c[3], c[4]} == "print")) k = KIND_PRINT;
    return k;
  endfunction

endpackage

### design/c_subset_tokenizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_subset_tokenizer_unit
// Streaming tokenizer for a small C-like language, one source byte per request.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one source byte per request, with in_source_last
//   set on the final byte of a text. The output channel delivers tokens as
//   kind, line, start offset and length; out_run_last marks the last token
//   caused by one byte and out_final_token the closing end token of a text.
//   A byte is tokenized in the cycle it is accepted and its tokens are
//   written into a three-entry output queue, so the first token appears in the
//   cycle after acceptance. The queue drains one token per cycle while the
//   receiver is ready, which sets the rate: a byte that yields at most one
//   token does not hold the input, one that yields two or three holds it
//   until the last queued token is taken. Whitespace and bytes inside a number
//   or identifier yield no token of their own. After the closing token the
//   scanner state returns to its reset values, and the next byte opens a new
//   text at offset 0, line 1. Reset empties the queue and clears the scanner
//   state. While the receiver stalls, the head token holds and no new byte
//   is accepted.
// ----------------------------------------------------------------------------
module c_subset_tokenizer_unit #(
  parameter int OFFSET_BITS   = 24,
  parameter int LINE_BITS     = 20,
  parameter int KEYWORD_CHARS = 6
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ctok_pkg::BYTE_W-1:0]    in_source_byte,
  input  logic                           in_source_last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ctok_pkg::kind_t                out_token_kind,
  output logic [ctok_pkg::LINE_W-1:0]    out_token_line,
  output logic [ctok_pkg::START_W-1:0]   out_token_start,
  output logic [ctok_pkg::LEN_W-1:0]     out_token_length,
  output logic                           out_final_token,
  output logic                           out_run_last
);
  import ctok_pkg::*;

  localparam int KW_IDX_W = $clog2(KEYWORD_CHARS);
  localparam logic [OFFSET_BITS-1:0] POS_MAX   = '1;
  localparam logic [LINE_BITS-1:0]   LINE_MAX  = '1;
  localparam logic [LEN_W-1:0]       COUNT_MAX = '1;

  typedef enum logic [2:0] {
    PK_NONE, PK_NUM, PK_IDENT, PK_EQ, PK_BANG, PK_LT, PK_GT
  } pend_t;

  typedef logic [BYTE_W-1:0] kbuf_t [KEYWORD_CHARS];

  function automatic logic [LINE_W-1:0] line_field(input logic [LINE_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[LINE_W-1:0];
  endfunction

  function automatic logic [START_W-1:0] start_field(input logic [OFFSET_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[START_W-1:0];
  endfunction

  function automatic kind_t flush_kind(input pend_t p, input logic [LEN_W-1:0] cnt,
                                       input logic [KW_LEN_MAX-1:0][BYTE_W-1:0] c);
    kind_t k;
    case (p)
      PK_NUM:   k = KIND_NUMBER;
      PK_IDENT: k = keyword_kind(c, cnt);
      PK_EQ:    k = KIND_ASSIGN;
      PK_LT:    k = KIND_LT;
      PK_GT:    k = KIND_GT;
      default:  k = KIND_EOF;
    endcase
    return k;
  endfunction

  function automatic logic [LEN_W-1:0] flush_len(input pend_t p, input logic [LEN_W-1:0] cnt);
    logic [LEN_W-1:0] n;
    case (p)
      PK_NUM, PK_IDENT:   n = cnt;
      PK_EQ, PK_LT, PK_GT: n = LEN_W'(1);
      default:            n = '0;
    endcase
    return n;
  endfunction

  // Scanner state.
  pend_t                  pend_r, pend_nxt;
  logic [OFFSET_BITS-1:0] tok_begin_r, tok_begin_nxt;
  logic [LEN_W-1:0]       count_r, count_nxt;
  kbuf_t                  kbuf_r, kbuf_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;

  // Output queue.
  token_t     q_r [3];
  token_t     push_q [3];
  logic [1:0] qcnt_r;
  logic [1:0] push_n;

  logic in_acc, pop;

  // Scratch values of the combinational pass.
  logic [BYTE_W-1:0]                 b;
  logic                              dig, word, eq, op;
  logic                              taken;
  pend_t                             op_pend;
  logic [LEN_W-1:0]                  count_inc;
  logic [OFFSET_BITS-1:0]            pos_inc;
  logic [LINE_BITS-1:0]              line_emit;
  logic [KW_LEN_MAX-1:0][BYTE_W-1:0] kw_cur, kw_nxt;
  token_t                            t0, t1, t2;
  logic                              v0, v1, v2;

  assign pop      = (qcnt_r != 2'd0) && out_ready;
  assign in_ready = (qcnt_r == 2'd0) || ((qcnt_r == 2'd1) && out_ready);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    b    = in_source_byte;
    dig  = is_digit(b);
    word = dig || is_alpha_us(b);
    eq   = (b == CH_EQ);

    op      = 1'b1;
    op_pend = PK_NONE;
    case (b)
      CH_EQ:   op_pend = PK_EQ;
      CH_BANG: op_pend = PK_BANG;
      CH_LT:   op_pend = PK_LT;
      CH_GT:   op_pend = PK_GT;
      default: op = 1'b0;
    endcase

    for (int i = 0; i < KW_LEN_MAX; i++) kw_cur[i] = kbuf_r[i];

    pend_nxt      = pend_r;
    tok_begin_nxt = tok_begin_r;
    count_nxt     = count_r;
    kbuf_nxt      = kbuf_r;
    line_nxt      = line_r;
    count_inc     = (count_r != COUNT_MAX) ? count_r + LEN_W'(1) : count_r;
    pos_inc       = (pos_r != POS_MAX) ? pos_r + OFFSET_BITS'(1) : pos_r;
    pos_nxt       = pos_inc;
    taken         = 1'b0;

    t0 = '0;
    t1 = '0;
    t2 = '0;
    v0 = 1'b0;
    v1 = 1'b0;
    v2 = 1'b0;

    // The pending token either grows, pairs with '=' or is flushed.
    case (pend_r)
      PK_NUM: begin
        if (dig) begin
          taken     = 1'b1;
          count_nxt = count_inc;
        end
      end
      PK_IDENT: begin
        if (word) begin
          taken = 1'b1;
          if (count_r < LEN_W'(KEYWORD_CHARS)) kbuf_nxt[count_r[KW_IDX_W-1:0]] = b;
          count_nxt = count_inc;
        end
      end
      PK_EQ, PK_BANG, PK_LT, PK_GT: begin
        if (eq) begin
          taken     = 1'b1;
          v0        = 1'b1;
          t0.length = LEN_W'(2);
          case (pend_r)
            PK_EQ:   t0.kind = KIND_EQEQ;
            PK_BANG: t0.kind = KIND_NE;
            PK_LT:   t0.kind = KIND_LE;
            default: t0.kind = KIND_GE;
          endcase
          pend_nxt = PK_NONE;
        end
      end
      default: ;
    endcase

    if ((pend_r != PK_NONE) && !taken) begin
      v0        = 1'b1;
      t0.kind   = flush_kind(pend_r, count_r, kw_cur);
      t0.length = flush_len(pend_r, count_r);
      pend_nxt  = PK_NONE;
    end
    t0.line  = line_field(line_r);
    t0.start = start_field(tok_begin_r);

    // A byte not absorbed by the pending token starts something new.
    if (!taken) begin
      if (is_space(b)) begin
        if ((b == CH_NL) && (line_r != LINE_MAX)) line_nxt = line_r + LINE_BITS'(1);
      end else if (word) begin
        pend_nxt      = dig ? PK_NUM : PK_IDENT;
        tok_begin_nxt = pos_r;
        count_nxt     = LEN_W'(1);
        kbuf_nxt[0]   = b;
      end else if (op) begin
        pend_nxt      = op_pend;
        tok_begin_nxt = pos_r;
      end else begin
        v1        = 1'b1;
        t1.kind   = punct_kind(b);
        t1.start  = start_field(pos_r);
        t1.length = (t1.kind != KIND_EOF) ? LEN_W'(1) : '0;
      end
    end
    line_emit = line_nxt;

    for (int i = 0; i < KW_LEN_MAX; i++) kw_nxt[i] = kbuf_nxt[i];

    // End of text: flush whatever is pending, then the closing token.
    if (in_source_last) begin
      if (pend_nxt != PK_NONE) begin
        v1        = 1'b1;
        t1.kind   = flush_kind(pend_nxt, count_nxt, kw_nxt);
        t1.start  = start_field(tok_begin_nxt);
        t1.length = flush_len(pend_nxt, count_nxt);
      end
      v2           = 1'b1;
      t2.kind      = KIND_EOF;
      t2.start     = start_field(pos_inc);
      t2.length    = '0;
      t2.final_tok = 1'b1;

      pend_nxt      = PK_NONE;
      tok_begin_nxt = '0;
      count_nxt     = '0;
      for (int i = 0; i < KEYWORD_CHARS; i++) kbuf_nxt[i] = '0;
      pos_nxt       = '0;
      line_nxt      = LINE_BITS'(1);
    end
    t1.line = line_field(line_emit);
    t2.line = line_field(line_emit);

    // Pack the valid tokens to the front of the queue in emission order.
    push_n = 2'(v0) + 2'(v1) + 2'(v2);
    push_q[0] = v0 ? t0 : (v1 ? t1 : t2);
    push_q[1] = (v0 && v1) ? t1 : t2;
    push_q[2] = t2;
    for (int i = 0; i < 3; i++) begin
      push_q[i].run_last = (2'(i) == (push_n - 2'd1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcnt_r      <= 2'd0;
      pend_r      <= PK_NONE;
      tok_begin_r <= '0;
      count_r     <= '0;
      for (int i = 0; i < KEYWORD_CHARS; i++) kbuf_r[i] <= '0;
      pos_r       <= '0;
      line_r      <= LINE_BITS'(1);
    end else begin
      if (in_acc) begin
        qcnt_r      <= push_n;
        pend_r      <= pend_nxt;
        tok_begin_r <= tok_begin_nxt;
        count_r     <= count_nxt;
        kbuf_r      <= kbuf_nxt;
        pos_r       <= pos_nxt;
        line_r      <= line_nxt;
      end else if (pop) begin
        qcnt_r <= qcnt_r - 2'd1;
      end
    end
  end

  // Queue payload. A request is only taken when the queue is empty or empties this cycle.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      q_r <= push_q;
    end else if (pop) begin
      q_r[0] <= q_r[1];
      q_r[1] <= q_r[2];
    end
  end

  assign out_valid        = (qcnt_r != 2'd0);
  assign out_token_kind   = q_r[0].kind;
  assign out_token_line   = q_r[0].line;
  assign out_token_start  = q_r[0].start;
  assign out_token_length = q_r[0].length;
  assign out_final_token  = q_r[0].final_tok;
  assign out_run_last     = q_r[0].run_last;

endmodule

### design/ctok_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctok_checker
// Port-level checks on the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module ctok_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [ctok_pkg::BYTE_W-1:0]  in_source_byte,
  input logic                         in_source_last,
  input logic                         out_valid,
  input logic                         out_ready,
  input ctok_pkg::kind_t              out_token_kind,
  input logic [ctok_pkg::LINE_W-1:0]  out_token_line,
  input logic [ctok_pkg::START_W-1:0] out_token_start,
  input logic [ctok_pkg::LEN_W-1:0]   out_token_length,
  input logic                         out_final_token,
  input logic                         out_run_last
);
  import ctok_pkg::*;

  // A stalled token holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_kind) &&
      $stable(out_token_line) && $stable(out_token_start) &&
      $stable(out_token_length) && $stable(out_final_token) && $stable(out_run_last))
    else $error("stalled token changed");

  // No new request while tokens of the previous one are still stuck.
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request accepted while output stalled");

  // The closing token ends its request and is an empty end token.
  a_final_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_final_token |->
      out_run_last && (out_token_kind == KIND_EOF) && (out_token_length == '0))
    else $error("malformed closing token");

  // End and unknown tokens are empty; every other token has text.
  a_length_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_token_kind == KIND_EOF) == (out_token_length == '0)))
    else $error("token length does not match kind");

endmodule

bind c_subset_tokenizer_unit ctok_checker u_ctok_checker (.*);
